>>> sv/vt4_pkg.sv
`default_nettype none

package vt4_pkg;

   localparam int WORD_W     = 32;
   localparam int PROD_W     = 2 * WORD_W;
   // four products of up to 2^62 need two guard bits
   localparam int SUM_W      = PROD_W + 2;
   localparam int NUM_LANES  = 4;
   localparam int NUM_COLS   = 4;
   localparam int NUM_REGS   = 8;
   localparam int REG_IDX_W  = $clog2(NUM_REGS);
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 64;

   // register indexes
   localparam logic [REG_IDX_W-1:0] COL_A_XY = REG_IDX_W'(0);
   localparam logic [REG_IDX_W-1:0] COL_A_ZW = REG_IDX_W'(1);
   localparam logic [REG_IDX_W-1:0] COL_B_XY = REG_IDX_W'(2);
   localparam logic [REG_IDX_W-1:0] COL_B_ZW = REG_IDX_W'(3);
   localparam logic [REG_IDX_W-1:0] COL_C_XY = REG_IDX_W'(4);
   localparam logic [REG_IDX_W-1:0] COL_C_ZW = REG_IDX_W'(5);
   localparam logic [REG_IDX_W-1:0] COL_D_XY = REG_IDX_W'(6);
   localparam logic [REG_IDX_W-1:0] COL_D_ZW = REG_IDX_W'(7);

   // identity matrix words: 1.0 in the low or the high half
   localparam logic [CSR_DATA_W-1:0] ONE_LOW  = 64'h0000_0000_0001_0000;
   localparam logic [CSR_DATA_W-1:0] ONE_HIGH = 64'h0001_0000_0000_0000;
   localparam logic [CSR_DATA_W-1:0] ZERO_REG = 64'h0000_0000_0000_0000;

   localparam logic [WORD_W-1:0] SAT_MAX = 32'h7fff_ffff;
   localparam logic [WORD_W-1:0] SAT_MIN = 32'h8000_0000;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef word_type quad_type [NUM_COLS];
   typedef logic [CSR_DATA_W-1:0] csr_word_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   typedef struct packed {
      logic mul_en;
      logic sum_en;
   } stage_en_type;

endpackage

`default_nettype wire

>>> sv/vt4_if.sv
`default_nettype none

interface vt4_req_if;
   logic              valid;
   logic              ready;
   vt4_pkg::word_type vec_x;
   vt4_pkg::word_type vec_y;
   vt4_pkg::word_type vec_z;
   vt4_pkg::word_type vec_w;

   modport source (output valid, output vec_x, output vec_y, output vec_z, output vec_w,
                   input ready);
   modport sink (input valid, input vec_x, input vec_y, input vec_z, input vec_w,
                 output ready);
endinterface

interface vt4_rsp_if;
   logic              valid;
   logic              ready;
   vt4_pkg::word_type res_x;
   vt4_pkg::word_type res_y;
   vt4_pkg::word_type res_z;
   vt4_pkg::word_type res_w;
   logic              overflow;

   modport source (output valid, output res_x, output res_y, output res_z, output res_w,
                   output overflow, input ready);
   modport sink (input valid, input res_x, input res_y, input res_z, input res_w,
                 input overflow, output ready);
endinterface

interface vt4_csr_if;
   logic                  valid;
   logic                  ready;
   vt4_pkg::csr_idx_type  index;
   vt4_pkg::csr_word_type wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

>>> sv/vt4_lane.sv
`default_nettype none

// one result component: four products, their sum, then shift and saturate
module vt4_lane #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                  clock,
   input  wire vt4_pkg::stage_en_type stage_en,
   input  wire vt4_pkg::quad_type     vec,
   input  wire vt4_pkg::quad_type     col_word,
   output vt4_pkg::word_type          result,
   output logic                       ovf
);

   logic signed [vt4_pkg::PROD_W-1:0] prod_ff [vt4_pkg::NUM_COLS];
   logic signed [vt4_pkg::SUM_W-1:0]  sum_in;
   logic signed [vt4_pkg::SUM_W-1:0]  sum_ff;
   logic signed [vt4_pkg::SUM_W-1:0]  shifted;
   logic [vt4_pkg::SUM_W-vt4_pkg::WORD_W:0] upper;
   logic fits;

   always_ff @(posedge clock) begin
      if (stage_en.mul_en) begin
         for (int c = 0; c < vt4_pkg::NUM_COLS; c++) begin
            prod_ff[c] <= vt4_pkg::PROD_W'(vec[c]) * vt4_pkg::PROD_W'(col_word[c]);
         end
      end
   end

   always_comb begin
      sum_in = '0;
      for (int c = 0; c < vt4_pkg::NUM_COLS; c++) begin
         sum_in = sum_in + vt4_pkg::SUM_W'(prod_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.sum_en) begin
         sum_ff <= sum_in;
      end
   end

   // arithmetic shift floors; result fits when bits 31 and up agree
   assign shifted = sum_ff >>> FRAC_BITS;
   assign upper   = shifted[vt4_pkg::SUM_W-1:vt4_pkg::WORD_W-1];
   assign fits    = (&upper) || (~|upper);
   assign ovf     = ~fits;

   always_comb begin
      if (fits) begin
         result = shifted[vt4_pkg::WORD_W-1:0];
      end else if (sum_ff[vt4_pkg::SUM_W-1]) begin
         result = vt4_pkg::SAT_MIN;
      end else begin
         result = vt4_pkg::SAT_MAX;
      end
   end

endmodule

`default_nettype wire

>>> sv/vt4_merge.sv
`default_nettype none

// output register: gathers the lane results and folds their overflow flags
module vt4_merge (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire vt4_pkg::quad_type lane_result,
   input  wire logic [vt4_pkg::NUM_LANES-1:0] lane_ovf,
   vt4_rsp_if.source              rsp_ch
);

   logic valid_ff;
   logic valid_in;
   vt4_pkg::quad_type res_ff;
   logic ovf_ff;

   assign in_ready = ~valid_ff | rsp_ch.ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         res_ff <= lane_result;
         ovf_ff <= |lane_ovf;
      end
   end

   assign rsp_ch.valid    = valid_ff;
   assign rsp_ch.res_x    = res_ff[0];
   assign rsp_ch.res_y    = res_ff[1];
   assign rsp_ch.res_z    = res_ff[2];
   assign rsp_ch.res_w    = res_ff[3];
   assign rsp_ch.overflow = ovf_ff;

endmodule

`default_nettype wire

>>> sv/vertex_transform_4x4.sv
`default_nettype none

// channel   modport  payload                                  transaction
// req_ch    sink     vec_x, vec_y, vec_z, vec_w (Q16.16)     valid && ready
// rsp_ch    source   res_x .. res_w (Q16.16), overflow        valid && ready
// csr_ch    sink     index (8 bits), wdata (64 bits)          valid && ready
//
// one vector per cycle unless rsp_ch stalls; product register, sum register,
// output register (the four lane multipliers set the first stage)
// reset loads the identity matrix and empties the pipeline
// each stage advances on its own, so a new vector is taken while a result waits
// csr writes are always taken; indexes above 7 are dropped
module vertex_transform_4x4 #(
   parameter int FRAC_BITS = 16
) (
   input wire logic   clock,
   input wire logic   reset,
   vt4_req_if.sink    req_ch,
   vt4_rsp_if.source  rsp_ch,
   vt4_csr_if.sink    csr_ch
);

   vt4_pkg::csr_word_type cfg_ff [vt4_pkg::NUM_REGS];

   logic mul_valid_ff, mul_valid_in;
   logic sum_valid_ff, sum_valid_in;
   logic mul_adv, sum_adv, out_ready;
   vt4_pkg::stage_en_type stage_en;
   vt4_pkg::quad_type vec;
   vt4_pkg::quad_type col_word [vt4_pkg::NUM_LANES];
   vt4_pkg::quad_type lane_result;
   logic [vt4_pkg::NUM_LANES-1:0] lane_ovf;

   // configuration registers
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[vt4_pkg::COL_A_XY] <= vt4_pkg::ONE_LOW;
         cfg_ff[vt4_pkg::COL_A_ZW] <= vt4_pkg::ZERO_REG;
         cfg_ff[vt4_pkg::COL_B_XY] <= vt4_pkg::ONE_HIGH;
         cfg_ff[vt4_pkg::COL_B_ZW] <= vt4_pkg::ZERO_REG;
         cfg_ff[vt4_pkg::COL_C_XY] <= vt4_pkg::ZERO_REG;
         cfg_ff[vt4_pkg::COL_C_ZW] <= vt4_pkg::ONE_LOW;
         cfg_ff[vt4_pkg::COL_D_XY] <= vt4_pkg::ZERO_REG;
         cfg_ff[vt4_pkg::COL_D_ZW] <= vt4_pkg::ONE_HIGH;
      end else if (csr_ch.valid &&
                   (csr_ch.index < vt4_pkg::CSR_IDX_W'(vt4_pkg::NUM_REGS))) begin
         cfg_ff[csr_ch.index[vt4_pkg::REG_IDX_W-1:0]] <= csr_ch.wdata;
      end
   end

   // pipeline control, each stage fills when the next one can move
   assign sum_adv      = ~sum_valid_ff | out_ready;
   assign mul_adv      = ~mul_valid_ff | sum_adv;
   assign req_ch.ready = mul_adv;

   assign stage_en.mul_en = req_ch.valid & mul_adv;
   assign stage_en.sum_en = mul_valid_ff & sum_adv;

   assign mul_valid_in = mul_adv ? req_ch.valid : mul_valid_ff;
   assign sum_valid_in = sum_adv ? mul_valid_ff : sum_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= mul_valid_in;
         sum_valid_ff <= sum_valid_in;
      end
   end

   assign vec[0] = req_ch.vec_x;
   assign vec[1] = req_ch.vec_y;
   assign vec[2] = req_ch.vec_z;
   assign vec[3] = req_ch.vec_w;

   // lane k takes component k of every column
   for (genvar k = 0; k < vt4_pkg::NUM_LANES; k++) begin : g_lane
      for (genvar c = 0; c < vt4_pkg::NUM_COLS; c++) begin : g_col
         localparam int RegIdx = 2 * c + k / 2;
         localparam int Half   = k % 2;
         assign col_word[k][c] = cfg_ff[RegIdx][vt4_pkg::WORD_W*Half +: vt4_pkg::WORD_W];
      end

      vt4_lane #(
         .FRAC_BITS (FRAC_BITS)
      ) u_lane (
         .clock    (clock),
         .stage_en (stage_en),
         .vec      (vec),
         .col_word (col_word[k]),
         .result   (lane_result[k]),
         .ovf      (lane_ovf[k])
      );
   end

   vt4_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (sum_valid_ff),
      .in_ready    (out_ready),
      .lane_result (lane_result),
      .lane_ovf    (lane_ovf),
      .rsp_ch      (rsp_ch)
   );

endmodule

`default_nettype wire

>>> tb/vt4_checker.sv
module vt4_checker #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   vt4_req_if        req_ch,
   vt4_rsp_if        rsp_ch,
   vt4_csr_if        csr_ch,
   output int        in_flight,
   output int        mismatches
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic signed [127:0] LANE_MAX = 128'sh7fff_ffff;
   localparam logic signed [127:0] LANE_MIN = -128'sh8000_0000;

   typedef struct packed {
      vt4_pkg::word_type res_x;
      vt4_pkg::word_type res_y;
      vt4_pkg::word_type res_z;
      vt4_pkg::word_type res_w;
      logic              overflow;
   } vertex_result_type;

   vt4_pkg::csr_word_type matrix_regs [vt4_pkg::NUM_REGS];
   vertex_result_type     expected_vertices [$];
   vertex_result_type     got_vertex;
   vertex_result_type     want_vertex;

   // column-weighted sum per lane, floor shift, then clamp to 32 bits
   function automatic vertex_result_type transform_vertex(
         input vt4_pkg::word_type vx, input vt4_pkg::word_type vy,
         input vt4_pkg::word_type vz, input vt4_pkg::word_type vw);
      vt4_pkg::word_type     weights [vt4_pkg::NUM_COLS];
      vt4_pkg::word_type     lanes [vt4_pkg::NUM_LANES];
      vt4_pkg::word_type     coef;
      vt4_pkg::csr_word_type column_half;
      logic signed [127:0]   acc;
      logic signed [127:0]   scaled;
      vertex_result_type     res;
      weights[0] = vx;
      weights[1] = vy;
      weights[2] = vz;
      weights[3] = vw;
      res.overflow = 1'b0;
      for (int lane = 0; lane < vt4_pkg::NUM_LANES; lane++) begin
         acc = '0;
         for (int col = 0; col < vt4_pkg::NUM_COLS; col++) begin
            column_half = matrix_regs[2 * col + lane / 2];
            coef = (lane % 2 != 0) ? column_half[63:32] : column_half[31:0];
            acc = acc + 128'(coef) * 128'(weights[col]);
         end
         scaled = acc >>> FRAC_BITS;
         if (scaled > LANE_MAX) begin
            lanes[lane] = vt4_pkg::SAT_MAX;
            res.overflow = 1'b1;
         end else if (scaled < LANE_MIN) begin
            lanes[lane] = vt4_pkg::SAT_MIN;
            res.overflow = 1'b1;
         end else begin
            lanes[lane] = scaled[vt4_pkg::WORD_W-1:0];
         end
      end
      res.res_x = lanes[0];
      res.res_y = lanes[1];
      res.res_z = lanes[2];
      res.res_w = lanes[3];
      return res;
   endfunction

   task automatic report_mismatch(input string what,
                                  input logic [vt4_pkg::WORD_W-1:0] got,
                                  input logic [vt4_pkg::WORD_W-1:0] want);
      mismatches++;
      $display("%0t: %s mismatch, got %h expected %h", $time, what, got, want);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         matrix_regs[vt4_pkg::COL_A_XY] = vt4_pkg::ONE_LOW;
         matrix_regs[vt4_pkg::COL_A_ZW] = vt4_pkg::ZERO_REG;
         matrix_regs[vt4_pkg::COL_B_XY] = vt4_pkg::ONE_HIGH;
         matrix_regs[vt4_pkg::COL_B_ZW] = vt4_pkg::ZERO_REG;
         matrix_regs[vt4_pkg::COL_C_XY] = vt4_pkg::ZERO_REG;
         matrix_regs[vt4_pkg::COL_C_ZW] = vt4_pkg::ONE_LOW;
         matrix_regs[vt4_pkg::COL_D_XY] = vt4_pkg::ZERO_REG;
         matrix_regs[vt4_pkg::COL_D_ZW] = vt4_pkg::ONE_HIGH;
         expected_vertices.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got_vertex = '{rsp_ch.res_x, rsp_ch.res_y, rsp_ch.res_z, rsp_ch.res_w,
                           rsp_ch.overflow};
            if (expected_vertices.size() == 0) begin
               report_mismatch("unexpected result", got_vertex.res_x, '0);
            end else begin
               want_vertex = expected_vertices.pop_front();
               if (got_vertex.res_x !== want_vertex.res_x)
                  report_mismatch("res_x", got_vertex.res_x, want_vertex.res_x);
               if (got_vertex.res_y !== want_vertex.res_y)
                  report_mismatch("res_y", got_vertex.res_y, want_vertex.res_y);
               if (got_vertex.res_z !== want_vertex.res_z)
                  report_mismatch("res_z", got_vertex.res_z, want_vertex.res_z);
               if (got_vertex.res_w !== want_vertex.res_w)
                  report_mismatch("res_w", got_vertex.res_w, want_vertex.res_w);
               if (got_vertex.overflow !== want_vertex.overflow)
                  report_mismatch("overflow", 32'(got_vertex.overflow),
                                  32'(want_vertex.overflow));
            end
         end
         if (req_ch.valid && req_ch.ready)
            expected_vertices.push_back(transform_vertex(req_ch.vec_x, req_ch.vec_y,
                                                         req_ch.vec_z, req_ch.vec_w));
         // indexes past the last register are dropped by the block
         if (csr_ch.valid && csr_ch.ready && csr_ch.index < vt4_pkg::NUM_REGS)
            matrix_regs[csr_ch.index[vt4_pkg::REG_IDX_W-1:0]] = csr_ch.wdata;
      end
      in_flight <= expected_vertices.size();
   end

endmodule

>>> tb/vertex_transform_4x4_tb.sv
module vertex_transform_4x4_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC_BITS      = 16;
   localparam int RANDOM_ITEMS   = 1530;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_PAUSE    = 8;
   localparam int SMALL_LIMIT    = 32'h0004_0000;
   localparam int CSR_IDX_LAST   = 2 ** vt4_pkg::CSR_IDX_W - 1;

   localparam vt4_pkg::word_type CORNER_WORDS [8] = '{
      32'h0000_0000, 32'h0000_0001, 32'hffff_ffff, 32'h0001_0000,
      32'hffff_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_8000
   };

   typedef enum int {SPAN_FULL, SPAN_SMALL, SPAN_CORNER} value_span_type;
   typedef enum int {SINK_OPEN, SINK_COIN, SINK_BURSTY} sink_mode_type;

   logic clock = 1'b0;
   logic reset;

   vt4_req_if req_ch ();
   vt4_rsp_if rsp_ch ();
   vt4_csr_if csr_ch ();

   int vertices_in_flight;
   int mismatch_count;
   int idle_cycles;
   int burst_left;
   int vertices_sent;
   bit req_holding;
   bit csr_holding;

   sink_mode_type sink_mode;
   int            mode_cycles;
   int            run_left;

   vertex_transform_4x4 #(.FRAC_BITS(FRAC_BITS)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   vt4_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_ch     (csr_ch),
      .in_flight  (vertices_in_flight),
      .mismatches (mismatch_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // result sink switches between stall styles at random
   always @(posedge clock) begin
      if (mode_cycles == 0) begin
         sink_mode <= sink_mode_type'($urandom_range(SINK_OPEN, SINK_BURSTY));
         mode_cycles <= $urandom_range(64, 512);
      end else begin
         mode_cycles <= mode_cycles - 1;
      end
      case (sink_mode)
         SINK_OPEN: begin
            rsp_ch.ready <= 1'b1;
         end
         SINK_COIN: begin
            rsp_ch.ready <= 1'($urandom_range(0, 1));
         end
         default: begin
            if (run_left == 0) begin
               rsp_ch.ready <= ~rsp_ch.ready;
               run_left <= $urandom_range(1, 30);
            end else begin
               run_left <= run_left - 1;
            end
         end
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic value_span_type pick_span();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 5)
         return SPAN_SMALL;
      else if (roll < 8)
         return SPAN_FULL;
      return SPAN_CORNER;
   endfunction

   function automatic vt4_pkg::word_type pick_word(input value_span_type span);
      case (span)
         SPAN_FULL:  return vt4_pkg::word_type'($urandom);
         SPAN_SMALL: return vt4_pkg::word_type'(int'($urandom_range(0, 2 * SMALL_LIMIT)) -
                                                SMALL_LIMIT);
         default:    return CORNER_WORDS[$urandom_range(0, 7)];
      endcase
   endfunction

   // vector transaction; valid stays up inside a burst
   task automatic send_vertex(input vt4_pkg::word_type x, input vt4_pkg::word_type y,
                              input vt4_pkg::word_type z, input vt4_pkg::word_type w);
      int gap;
      req_ch.valid <= 1'b1;
      req_ch.vec_x <= x;
      req_ch.vec_y <= y;
      req_ch.vec_z <= z;
      req_ch.vec_w <= w;
      req_holding = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      vertices_sent++;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            req_holding = 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic send_random_vertex();
      send_vertex(pick_word(pick_span()), pick_word(pick_span()), pick_word(pick_span()),
                  pick_word(pick_span()));
   endtask

   // hold off new vectors until every result is back
   task automatic settle();
      if (req_holding) begin
         req_ch.valid <= 1'b0;
         req_holding = 1'b0;
      end
      do @(posedge clock); while (vertices_in_flight != 0);
      repeat (DRAIN_PAUSE) @(posedge clock);
   endtask

   task automatic write_csr(input vt4_pkg::csr_idx_type idx,
                            input vt4_pkg::csr_word_type data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.wdata <= data;
      csr_holding = 1'b1;
      do @(posedge clock); while (!csr_ch.ready);
   endtask

   task automatic program_matrix(input vt4_pkg::csr_word_type words [vt4_pkg::NUM_REGS],
                                 input logic [vt4_pkg::NUM_REGS-1:0] mask, input bit stray);
      settle();
      for (int i = 0; i < vt4_pkg::NUM_REGS; i++)
         if (mask[i])
            write_csr(vt4_pkg::csr_idx_type'(i), words[i]);
      if (stray) begin
         write_csr(vt4_pkg::csr_idx_type'(vt4_pkg::NUM_REGS), {$urandom, $urandom});
         write_csr(vt4_pkg::csr_idx_type'($urandom_range(vt4_pkg::NUM_REGS, CSR_IDX_LAST)),
                   {$urandom, $urandom});
         write_csr(vt4_pkg::csr_idx_type'(CSR_IDX_LAST), '1);
      end
      if (csr_holding) begin
         csr_ch.valid <= 1'b0;
         csr_holding = 1'b0;
      end
   endtask

   initial begin
      vt4_pkg::csr_word_type        matrix_words [vt4_pkg::NUM_REGS];
      value_span_type               span;
      logic [vt4_pkg::NUM_REGS-1:0] mask;
      int                           phase_len;

      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.vec_x = '0;
      req_ch.vec_y = '0;
      req_ch.vec_z = '0;
      req_ch.vec_w = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.wdata = '0;
      sink_mode = SINK_OPEN;
      mode_cycles = 0;
      run_left = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // identity after reset passes vectors through
      send_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_vertex(32'h0001_0000, 32'hffff_0000, 32'h0000_8000, 32'hffff_8000);
      send_vertex(32'hffff_ffff, 32'h0000_0001, 32'h7fff_ffff, 32'h8000_0000);

      // writes above the last register must leave the identity alone
      matrix_words[vt4_pkg::COL_A_XY] = vt4_pkg::ONE_LOW;
      matrix_words[vt4_pkg::COL_A_ZW] = vt4_pkg::ZERO_REG;
      matrix_words[vt4_pkg::COL_B_XY] = vt4_pkg::ONE_HIGH;
      matrix_words[vt4_pkg::COL_B_ZW] = vt4_pkg::ZERO_REG;
      matrix_words[vt4_pkg::COL_C_XY] = vt4_pkg::ZERO_REG;
      matrix_words[vt4_pkg::COL_C_ZW] = vt4_pkg::ONE_LOW;
      matrix_words[vt4_pkg::COL_D_XY] = vt4_pkg::ZERO_REG;
      matrix_words[vt4_pkg::COL_D_ZW] = vt4_pkg::ONE_HIGH;
      program_matrix(matrix_words, '0, 1'b1);
      send_vertex(32'h1234_5678, 32'hedcb_a988, 32'h0000_ffff, 32'hffff_0001);

      // every word at the most negative value: largest sum and both overflows
      foreach (matrix_words[i]) matrix_words[i] = {vt4_pkg::SAT_MIN, vt4_pkg::SAT_MIN};
      program_matrix(matrix_words, '1, 1'b0);
      send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      send_vertex(32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_vertex(32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_vertex(32'hffff_ffff, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);

      foreach (matrix_words[i]) matrix_words[i] = {vt4_pkg::SAT_MAX, vt4_pkg::SAT_MAX};
      program_matrix(matrix_words, '1, 1'b0);
      send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000);

      // fractional weights: negative sums must round toward minus infinity
      matrix_words[vt4_pkg::COL_A_XY] = {32'h0000_4000, 32'h0000_8000};
      matrix_words[vt4_pkg::COL_A_ZW] = {32'hffff_c000, 32'h0000_0001};
      matrix_words[vt4_pkg::COL_B_XY] = {32'hffff_8000, 32'hffff_ffff};
      matrix_words[vt4_pkg::COL_B_ZW] = {32'h0000_0000, 32'h0002_0000};
      matrix_words[vt4_pkg::COL_C_XY] = {32'h0000_0003, 32'hfffe_0000};
      matrix_words[vt4_pkg::COL_C_ZW] = {32'h0000_0000, 32'h0001_0000};
      matrix_words[vt4_pkg::COL_D_XY] = {32'h7fff_ffff, 32'h0000_0000};
      matrix_words[vt4_pkg::COL_D_ZW] = {32'hffff_ffff, 32'h8000_0000};
      program_matrix(matrix_words, '1, 1'b0);
      send_vertex(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      send_vertex(32'h0000_0003, 32'hffff_fffd, 32'h0000_ffff, 32'hffff_0001);
      send_vertex(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);

      // x scaled by 2.0: results just inside and just past both saturation limits
      matrix_words[vt4_pkg::COL_A_XY] = {32'h0000_0000, 32'h0002_0000};
      matrix_words[vt4_pkg::COL_A_ZW] = vt4_pkg::ZERO_REG;
      matrix_words[vt4_pkg::COL_B_XY] = vt4_pkg::ONE_HIGH;
      matrix_words[vt4_pkg::COL_B_ZW] = vt4_pkg::ZERO_REG;
      matrix_words[vt4_pkg::COL_C_XY] = vt4_pkg::ZERO_REG;
      matrix_words[vt4_pkg::COL_C_ZW] = vt4_pkg::ONE_LOW;
      matrix_words[vt4_pkg::COL_D_XY] = vt4_pkg::ZERO_REG;
      matrix_words[vt4_pkg::COL_D_ZW] = vt4_pkg::ONE_HIGH;
      program_matrix(matrix_words, '1, 1'b0);
      send_vertex(32'h3fff_ffff, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003);
      send_vertex(32'h4000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003);
      send_vertex(32'hc000_0000, 32'hffff_ffff, 32'hffff_fffe, 32'hffff_fffd);
      send_vertex(32'hbfff_ffff, 32'hffff_ffff, 32'hffff_fffe, 32'hffff_fffd);

      vertices_sent = 0;
      while (vertices_sent < RANDOM_ITEMS) begin
         span = pick_span();
         foreach (matrix_words[i]) matrix_words[i] = {pick_word(span), pick_word(span)};
         mask = ($urandom_range(0, 2) == 0) ? vt4_pkg::NUM_REGS'($urandom) : '1;
         program_matrix(matrix_words, mask, 1'($urandom_range(0, 1)));
         phase_len = $urandom_range(100, 200);
         for (int n = 0; n < phase_len && vertices_sent < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 249) == 0)
               settle();
            send_random_vertex();
         end
      end

      settle();
      if (mismatch_count == 0 && vertices_in_flight == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

>>> sim.f
sv/vt4_pkg.sv
sv/vt4_if.sv
sv/vt4_lane.sv
sv/vt4_merge.sv
sv/vertex_transform_4x4.sv
tb/vt4_checker.sv
tb/vertex_transform_4x4_tb.sv
